FILE: rtl/occupancy_certainty_merge_defines.svh
// Assertion macros used by the occupancy merge controller.
`ifndef OCCUPANCY_CERTAINTY_MERGE_DEFINES_SVH
`define OCCUPANCY_CERTAINTY_MERGE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define OCM_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("ocm assertion failed");

// Next-cycle implication, held off during reset.
`define OCM_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("ocm assertion failed");

`endif

FILE: rtl/ocm_pkg.sv
// Types and constants of the occupancy certainty merge block.
`default_nettype none
package ocm_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned CountW    = 13;
  localparam int unsigned SumW      = 21;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned AvgW      = 17;
  localparam int unsigned DivW      = SumW + FracBits;
  localparam int unsigned DivCntW   = $clog2(DivW);
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 40;

  localparam logic [PixW-1:0]    UnknownPixel = 8'd127;
  localparam logic [PixW-1:0]    DevBaseReset = 8'd128;
  localparam logic [CountW-1:0]  MaxPixels    = 13'd4096;
  localparam logic [DivCntW-1:0] DivLastStep  = DivCntW'(DivW - 1);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StWait
  } ocm_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic take;        // input beat accepted
    logic start_div;   // accepted beat is the last one of the map
    logic load_total;  // move the finished average into the output register
  } ocm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;    // output register empty or being taken this cycle
    logic div_done;    // divider runs its final step this cycle
  } ocm_sts_t;

endpackage
`default_nettype wire

FILE: rtl/ocm_ctrl.sv
// Controller: input handshake and sequencing of the end-of-map division.
`default_nettype none
`include "occupancy_certainty_merge_defines.svh"
module ocm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  input  wire ocm_pkg::ocm_sts_t sts_i,
  output ocm_pkg::ocm_cmd_t  cmd_o
);

  ocm_pkg::ocm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ocm_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ocm_pkg::StIdle: begin
        if (in_valid_i && sts_i.out_free && in_last_i) state_d = ocm_pkg::StDiv;
      end
      ocm_pkg::StDiv: begin
        if (sts_i.div_done) state_d = ocm_pkg::StWait;
      end
      ocm_pkg::StWait: begin
        if (sts_i.out_free) state_d = ocm_pkg::StIdle;
      end
      default: state_d = ocm_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      ocm_pkg::StIdle: begin
        in_ready_o      = sts_i.out_free;
        cmd_o.take      = in_valid_i && sts_i.out_free;
        cmd_o.start_div = in_valid_i && sts_i.out_free && in_last_i;
      end
      ocm_pkg::StDiv: begin
      end
      ocm_pkg::StWait: begin
        cmd_o.load_total = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

  `OCM_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, state_q != ocm_pkg::StIdle, !in_ready_o)
  `OCM_ASSERT_NXT(a_last_starts_div, clk_i, rst_ni, cmd_o.start_div, state_q == ocm_pkg::StDiv)
  `OCM_ASSERT_NXT(a_total_returns, clk_i, rst_ni, cmd_o.load_total, state_q == ocm_pkg::StIdle)
  `OCM_ASSERT_IMP(a_done_in_div, clk_i, rst_ni, sts_i.div_done, state_q == ocm_pkg::StDiv)

endmodule
`default_nettype wire

FILE: rtl/ocm_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module ocm_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [ocm_pkg::SumW-1:0]   sum_i,
  input  wire logic [ocm_pkg::CountW-1:0]        count_i,
  output logic                              done_o,
  output logic signed [ocm_pkg::AvgW-1:0]   avg_o
);

  logic                             busy_q;
  logic [ocm_pkg::DivCntW-1:0]      cnt_q;
  logic                             neg_q;
  logic [ocm_pkg::CountW-1:0]       divisor_q;
  logic [ocm_pkg::CountW-1:0]       rem_q;
  logic [ocm_pkg::DivW-1:0]         quo_q;
  logic [ocm_pkg::SumW-1:0]         mag;
  logic [ocm_pkg::CountW:0]         trial;
  logic [ocm_pkg::CountW+1:0]       diff;
  logic                             ge;
  logic [ocm_pkg::DivW-1:0]         quo_signed;

  assign mag   = sum_i[ocm_pkg::SumW-1] ? (~sum_i + 1'b1) : sum_i;
  assign trial = {rem_q, quo_q[ocm_pkg::DivW-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_q};
  assign ge    = !diff[ocm_pkg::CountW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == ocm_pkg::DivLastStep) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q     <= sum_i[ocm_pkg::SumW-1];
      divisor_q <= (count_i == '0) ? ocm_pkg::CountW'(1) : count_i;
      rem_q     <= '0;
      quo_q     <= {mag, {ocm_pkg::FracBits{1'b0}}};
    end else if (busy_q) begin
      rem_q <= ge ? diff[ocm_pkg::CountW-1:0] : trial[ocm_pkg::CountW-1:0];
      quo_q <= {quo_q[ocm_pkg::DivW-2:0], ge};
    end
  end

  assign done_o     = busy_q && (cnt_q == ocm_pkg::DivLastStep);
  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign avg_o      = quo_signed[ocm_pkg::AvgW-1:0];

endmodule
`default_nettype wire

FILE: rtl/ocm_dp.sv
// Datapath: pixel merge, accumulators, deviation register and output register.
`default_nettype none
module ocm_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [ocm_pkg::PixW-1:0]      cfg_data_i,
  input  wire logic [ocm_pkg::PixW-1:0]      new_pixel_i,
  input  wire logic [ocm_pkg::PixW-1:0]      map_pixel_i,
  input  wire ocm_pkg::ocm_cmd_t             cmd_i,
  output ocm_pkg::ocm_sts_t                  sts_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_last_o,
  output logic [ocm_pkg::PixW-1:0]           merged_pixel_o,
  output logic                               write_map_o,
  output logic [ocm_pkg::CountW-1:0]         changed_count_o,
  output logic signed [ocm_pkg::AvgW-1:0]    avg_o
);

  logic [ocm_pkg::PixW-1:0]          dev_base_q;
  logic [ocm_pkg::CountW-1:0]        count_q, acc_count;
  logic signed [ocm_pkg::SumW-1:0]   sum_q, acc_sum;
  logic [ocm_pkg::PixW-1:0]          c_new, c_map;
  logic                              replace, upd;
  logic signed [ocm_pkg::PixW:0]     contrib;
  logic [ocm_pkg::PixW-1:0]          merged;
  logic [ocm_pkg::PixW-1:0]          hold_pix_q;
  logic                              hold_wr_q;
  logic                              out_valid_q;
  logic                              out_free;
  logic                              div_done;
  logic signed [ocm_pkg::AvgW-1:0]   div_avg;

  assign c_new   = (new_pixel_i >= ocm_pkg::UnknownPixel) ? (new_pixel_i - ocm_pkg::UnknownPixel)
                                                          : (ocm_pkg::UnknownPixel - new_pixel_i);
  assign c_map   = (map_pixel_i >= ocm_pkg::UnknownPixel) ? (map_pixel_i - ocm_pkg::UnknownPixel)
                                                          : (ocm_pkg::UnknownPixel - map_pixel_i);
  assign replace = c_new > c_map;
  assign upd     = replace && (new_pixel_i != ocm_pkg::UnknownPixel)
                   && (count_q < ocm_pkg::MaxPixels);
  assign contrib = $signed({1'b0, dev_base_q}) - $signed({1'b0, c_new});
  assign merged  = replace ? new_pixel_i : map_pixel_i;

  assign acc_count = upd ? (count_q + 1'b1) : count_q;
  assign acc_sum   = upd ? (sum_q + ocm_pkg::SumW'(contrib)) : sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_base_q <= ocm_pkg::DevBaseReset;
      count_q    <= '0;
      sum_q      <= '0;
    end else begin
      if (cfg_valid_i) dev_base_q <= cfg_data_i;
      if (cmd_i.start_div) begin
        count_q <= '0;
        sum_q   <= '0;
      end else if (cmd_i.take) begin
        count_q <= acc_count;
        sum_q   <= acc_sum;
      end
    end
  end

  // Park the merge result of the last beat while the average is computed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      hold_pix_q <= merged;
      hold_wr_q  <= replace;
    end
  end

  ocm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_div),
    .sum_i   (acc_sum),
    .count_i (acc_count),
    .done_o  (div_done),
    .avg_o   (div_avg)
  );

  logic [ocm_pkg::CountW-1:0] total_count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) total_count_q <= acc_count;
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.take && !cmd_i.start_div) || cmd_i.load_total) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_total) begin
      merged_pixel_o  <= hold_pix_q;
      write_map_o     <= hold_wr_q;
      out_last_o      <= 1'b1;
      changed_count_o <= total_count_q;
      avg_o           <= div_avg;
    end else if (cmd_i.take && !cmd_i.start_div) begin
      merged_pixel_o  <= merged;
      write_map_o     <= replace;
      out_last_o      <= 1'b0;
      changed_count_o <= '0;
      avg_o           <= '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = out_free;
  assign sts_o.div_done = div_done;

endmodule
`default_nettype wire

FILE: rtl/occupancy_certainty_merge.sv
// Top level of the occupancy certainty merge block.
// Usage:
//   Slave stream s_axis carries one pixel pair per beat; s_axis_tlast_i marks the
//   final pixel of a local map. Master stream m_axis returns one result beat per
//   input beat, in order; m_axis_tlast_o flags the beat that carries the totals.
//   The cfg channel writes deviation_base; cfg_ready_o is always high. Write it
//   only while no beat is in flight.
// Timing:
//   Ordinary beats leave in the cycle after acceptance through the output register,
//   one beat per cycle while the sink keeps up.
//   The last beat of a map starts a one-bit-per-cycle restoring divider for the
//   average; its result enters the output register after 29 divider steps, once
//   that register is free, and s_axis_tready_o is low meanwhile.
// Reset:
//   Clears the count and sum, loads deviation_base with 128, empties the output.
// Stalls:
//   While m_axis_tready_i is low and a result waits, s_axis_tready_o drops and
//   the result holds; no beat is lost.
`default_nettype none
module occupancy_certainty_merge (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ocm_pkg::PixW-1:0]      cfg_data_i,     // deviation_base
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [7:0] new_pixel, [15:8] map_pixel
  input  wire logic [ocm_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  wire logic                          s_axis_tlast_i, // is_last
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [7:0] merged_pixel, [8] write_map, [21:9] changed_count,
  // [38:22] avg_deviation_q8, [39] zero
  output logic [ocm_pkg::OutDataW-1:0]       m_axis_tdata_o,
  output logic                               m_axis_tlast_o  // last_out
);

  ocm_pkg::ocm_cmd_t cmd;
  ocm_pkg::ocm_sts_t sts;

  logic [ocm_pkg::PixW-1:0]        merged_pixel;
  logic                            write_map;
  logic [ocm_pkg::CountW-1:0]      changed_count;
  logic signed [ocm_pkg::AvgW-1:0] avg;

  assign cfg_ready_o = 1'b1;

  ocm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ocm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .new_pixel_i     (s_axis_tdata_i[7:0]),
    .map_pixel_i     (s_axis_tdata_i[15:8]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_last_o      (m_axis_tlast_o),
    .merged_pixel_o  (merged_pixel),
    .write_map_o     (write_map),
    .changed_count_o (changed_count),
    .avg_o           (avg)
  );

  assign m_axis_tdata_o = {1'b0, avg, changed_count, write_map, merged_pixel};

endmodule
`default_nettype wire

FILE: bench/occupancy_certainty_merge_tb.sv
// Self-checking testbench for the occupancy certainty merge block.
`default_nettype none
module occupancy_certainty_merge_tb;

  localparam int unsigned TimeoutCycles = 1_500_000;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned RandomItems   = 1830;

  typedef struct packed {
    logic [7:0]  merged;
    logic        write;
    logic        last;
    logic [12:0] count;
    logic [16:0] avg;
  } merge_result_t;

  // Tracks the merge totals and holds the results still owed by the block.
  class merge_tracker;
    logic [7:0]         dev_base;
    logic [12:0]        repl_count;
    logic signed [20:0] dev_sum;
    merge_result_t      due_results[$];
    int unsigned        mismatches;

    function new();
      dev_base   = ocm_pkg::DevBaseReset;
      repl_count = '0;
      dev_sum    = '0;
      mismatches = 0;
    endfunction

    function automatic logic [7:0] certainty(logic [7:0] p);
      return (p >= ocm_pkg::UnknownPixel) ? p - ocm_pkg::UnknownPixel
                                          : ocm_pkg::UnknownPixel - p;
    endfunction

    function void note_pixel(logic [7:0] np, logic [7:0] mp, logic last);
      logic [7:0]    c_new;
      logic          take;
      longint        divisor;
      longint        avg;
      merge_result_t r;
      c_new = certainty(np);
      take  = c_new > certainty(mp);
      if (take && np != ocm_pkg::UnknownPixel && repl_count < ocm_pkg::MaxPixels) begin
        repl_count = repl_count + 13'd1;
        dev_sum    = dev_sum + $signed({13'd0, dev_base}) - $signed({13'd0, c_new});
      end
      r.merged = take ? np : mp;
      r.write  = take;
      r.last   = last;
      r.count  = '0;
      r.avg    = '0;
      if (last) begin
        divisor    = (repl_count != 0) ? longint'(repl_count) : 64'sd1;
        avg        = (longint'(dev_sum) * 256) / divisor;
        r.count    = repl_count;
        r.avg      = avg[16:0];
        repl_count = '0;
        dev_sum    = '0;
      end
      due_results.push_back(r);
    endfunction

    function void check_result(logic [39:0] data, logic last);
      merge_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: data=%h last=%b", data, last);
        return;
      end
      want = due_results.pop_front();
      if (data[7:0] !== want.merged || data[8] !== want.write || data[21:9] !== want.count ||
          data[38:22] !== want.avg || data[39] !== 1'b0 || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: pix %h/%h wr %b/%b last %b/%b cnt %0d/%0d avg %h/%h pad %b",
                   want.merged, data[7:0], want.write, data[8], want.last, last,
                   want.count, data[21:9], want.avg, data[38:22], data[39]);
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i      = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;  // [7:0] new_pixel, [15:8] map_pixel
  logic        s_axis_tlast_i  = 1'b0; // is_last
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [7:0] merged_pixel, [8] write_map, [21:9] changed_count, [38:22] avg_deviation_q8
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;        // last_out

  merge_tracker tracker = new();
  int unsigned  cycles = 0;
  int unsigned  sink_hold = 0;
  int unsigned  sink_free = 0;

  occupancy_certainty_merge dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 11))
      0: return 8'd0;
      1: return 8'd255;
      2: return ocm_pkg::UnknownPixel;
      3: return 8'd126;
      4: return 8'd128;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > TimeoutCycles) begin
      $display("occupancy_certainty_merge_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o)
      tracker.note_pixel(s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tlast_i);
    if (m_axis_tvalid_o && m_axis_tready_i)
      tracker.check_result(m_axis_tdata_o, m_axis_tlast_o);
  end

  // Sink: alternate free-running stretches with random stalls.
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold--;
      m_axis_tready_i <= 1'b0;
    end else if (sink_free != 0) begin
      sink_free--;
      m_axis_tready_i <= 1'b1;
    end else begin
      sink_free = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 5);
      sink_hold = gap_len();
      m_axis_tready_i <= (sink_hold == 0);
    end
  end

  // Enter and leave on a rising edge; valid stays high with the accepted beat.
  task automatic send_pixel(input logic [7:0] np, input logic [7:0] mp, input logic last,
                            input bit gaps);
    int unsigned idle;
    idle = gaps ? gap_len() : 0;
    if (idle != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {mp, np};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Hold off the source until every result is back and the divider is idle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    // Let the monitor note the beat accepted at this edge first.
    @(posedge clk_i);
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.dev_base = value;
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    bit          gaps;
    sent = 0;
    while (sent < target) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 20);
      gaps = $urandom_range(0, 3) != 0;
      for (k = 0; k < len; k++)
        send_pixel(rand_pixel(), rand_pixel(), k == len - 1, gaps);
      sent += len;
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset base: full certainty, ties, unknowns, then a map ending on a tie.
    send_pixel(8'd255, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd0, 8'd254, 1'b0, 1'b0);
    send_pixel(ocm_pkg::UnknownPixel, ocm_pkg::UnknownPixel, 1'b0, 1'b0);
    send_pixel(ocm_pkg::UnknownPixel, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd0, ocm_pkg::UnknownPixel, 1'b0, 1'b0);
    send_pixel(8'd128, ocm_pkg::UnknownPixel, 1'b0, 1'b0);
    send_pixel(8'd126, 8'd128, 1'b1, 1'b0);
    // Map with nothing replaced, then a one-pixel map.
    send_pixel(ocm_pkg::UnknownPixel, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd200, ocm_pkg::UnknownPixel, 1'b1, 1'b0);
    drain();

    // Zero base: negative average that truncates toward zero.
    write_base(8'd0);
    send_pixel(8'd255, ocm_pkg::UnknownPixel, 1'b0, 1'b0);
    send_pixel(8'd0, ocm_pkg::UnknownPixel, 1'b0, 1'b0);
    send_pixel(8'd129, ocm_pkg::UnknownPixel, 1'b1, 1'b0);
    drain();

    // Full base: largest positive average.
    write_base(8'd255);
    send_pixel(8'd128, ocm_pkg::UnknownPixel, 1'b0, 1'b0);
    send_pixel(8'd126, ocm_pkg::UnknownPixel, 1'b1, 1'b0);
    drain();

    write_base(8'd0);
    run_random(RandomItems / 5);
    drain();
    write_base(8'd255);
    run_random(RandomItems / 5);
    drain();
    write_base(ocm_pkg::DevBaseReset);
    run_random(RandomItems / 5);
    drain();
    write_base(8'($urandom));
    run_random(RandomItems / 5);
    drain();
    write_base(8'($urandom));
    run_random(RandomItems / 5);
    drain();

    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("occupancy_certainty_merge_tb: clean");
    end else begin
      $display("occupancy_certainty_merge_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
